// ----- design/wss_pkg.sv -----
// Shared constants for the waveset segmenter.
package wss_pkg;

    localparam int POS_BITS_DEF    = 20;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int QUEUE_DEPTH     = 4;

    // Pack bits up to whole bytes.
    function automatic int byte_round(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

// ----- design/wss_queue.sv -----
// Small record queue between the sample classifier and the output stage.
module wss_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = wss_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_head
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign o_head    = r_slot[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ----- design/wss_front.sv -----
// Sample classifier: sign tracking, waveset state and record building.
module wss_front #(
    parameter int POS_BITS    = wss_pkg::POS_BITS_DEF,
    parameter int SAMPLE_BITS = wss_pkg::SAMPLE_BITS_DEF,
    localparam int REC_W      = 4 * POS_BITS + SAMPLE_BITS,
    localparam int ENTRY_W    = 2 + 2 * REC_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_buffer_last,
    input  logic                   i_queue_full,
    output logic                   o_push,
    output logic [ENTRY_W-1:0]     o_entry
);
    localparam logic [POS_BITS-1:0] POS_TOP = '1;

    logic                   r_prev_neg, r_second;
    logic [POS_BITS-1:0]    r_start, r_half, r_pos, r_count;
    logic [SAMPLE_BITS-1:0] r_peak;

    logic                   n_second;
    logic [POS_BITS-1:0]    n_start, n_half, n_count;
    logic [SAMPLE_BITS-1:0] n_peak, w_peak_mid;
    logic                   w_accept, w_neg, w_cross, w_close;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [REC_W-1:0]       w_rec_close, w_rec_final;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;

    // Two's complement negate gives 2^(N-1) for the most negative code.
    assign w_neg   = i_sample[SAMPLE_BITS-1];
    assign w_mag   = w_neg ? (~i_sample + 1'b1) : i_sample;
    assign w_cross = (r_pos != '0) && (w_neg != r_prev_neg);
    assign w_close = w_cross && r_second;

    always_comb begin
        n_second   = r_second;
        n_start    = r_start;
        n_half     = r_half;
        w_peak_mid = r_peak;
        n_count    = r_count;
        if (w_cross) begin
            if (!r_second) begin
                n_half   = r_pos;
                n_second = 1'b1;
            end else begin
                n_start    = r_pos;
                n_half     = r_pos;
                w_peak_mid = '0;
                n_second   = 1'b0;
                if (r_count != POS_TOP) begin
                    n_count = r_count + 1'b1;
                end
            end
        end
        n_peak = (w_mag > w_peak_mid) ? w_mag : w_peak_mid;
    end

    assign w_rec_close = {r_count, r_peak, r_pos - 1'b1, r_half, r_start};
    assign w_rec_final = {n_count, n_peak, r_pos, n_half, n_start};

    assign o_push  = w_accept && (w_close || i_buffer_last);
    assign o_entry = {w_close, i_buffer_last, w_rec_close, w_rec_final};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_neg <= 1'b0;
            r_second   <= 1'b0;
            r_start    <= '0;
            r_half     <= '0;
            r_peak     <= '0;
            r_pos      <= '0;
            r_count    <= '0;
        end else if (w_accept) begin
            if (i_buffer_last) begin
                // Buffer done: start over for the next one.
                r_prev_neg <= 1'b0;
                r_second   <= 1'b0;
                r_start    <= '0;
                r_half     <= '0;
                r_peak     <= '0;
                r_pos      <= '0;
                r_count    <= '0;
            end else begin
                r_prev_neg <= w_neg;
                r_second   <= n_second;
                r_start    <= n_start;
                r_half     <= n_half;
                r_peak     <= n_peak;
                r_count    <= n_count;
                if (r_pos != POS_TOP) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

endmodule

// ----- design/wss_back.sv -----
// Output stage: splits queued entries into records and holds the stream register.
module wss_back #(
    parameter int POS_BITS    = wss_pkg::POS_BITS_DEF,
    parameter int SAMPLE_BITS = wss_pkg::SAMPLE_BITS_DEF,
    localparam int REC_W      = 4 * POS_BITS + SAMPLE_BITS,
    localparam int ENTRY_W    = 2 + 2 * REC_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  logic [ENTRY_W-1:0] i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [REC_W-1:0]   o_rec,
    output logic               o_closes,
    output logic               o_last
);
    logic             r_valid, r_phase, r_closes, r_last;
    logic [REC_W-1:0] r_rec;
    logic             w_has_close, w_has_final, w_load, w_take_close;
    logic [REC_W-1:0] w_rec_close, w_rec_final;

    assign {w_has_close, w_has_final, w_rec_close, w_rec_final} = i_head;

    assign w_load       = (!r_valid || i_ready) && !i_empty;
    // Closed waveset goes first; hold the entry if a final record follows.
    assign w_take_close = w_has_close && !r_phase;
    assign o_pop        = w_load && !(w_take_close && w_has_final);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_phase <= w_take_close && w_has_final;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_take_close) begin
                r_rec    <= w_rec_close;
                r_closes <= 1'b0;
                r_last   <= !w_has_final;
            end else begin
                r_rec    <= w_rec_final;
                r_closes <= 1'b1;
                r_last   <= 1'b1;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_rec    = r_rec;
    assign o_closes = r_closes;
    assign o_last   = r_last;

endmodule

// ----- design/waveset_segmenter.sv -----
// Waveset segmenter top level: classifier, record queue and output stage.
// Output path: m_axis_tvalid rises after the sample's transaction through the queue write,
// then the output register load; a stalled output register holds the entry in the queue.
// Throughput: one sample per cycle while the queue is not full; a sample that closes
// a waveset on the buffer's last sample yields two records, sent as two transactions.
// The record queue holds wss_pkg::QUEUE_DEPTH entries between classifier and output.
// Synchronous active-low reset clears waveset state, queue and output valid.
module waveset_segmenter #(
    parameter int POS_BITS    = wss_pkg::POS_BITS_DEF,
    parameter int SAMPLE_BITS = wss_pkg::SAMPLE_BITS_DEF,
    localparam int REC_W      = 4 * POS_BITS + SAMPLE_BITS,
    localparam int IN_W       = wss_pkg::byte_round(SAMPLE_BITS),
    localparam int OUT_W      = wss_pkg::byte_round(REC_W)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // sample
    input  logic             s_axis_tlast,  // buffer_last
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // start_pos, half_pos, end_pos, peak_level, waveset_index, zero fill
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic [0:0]       m_axis_tuser,  // closes_buffer
    output logic             m_axis_tlast   // run_last
);
    localparam int ENTRY_W = 2 + 2 * REC_W;

    logic               w_push, w_full, w_pop, w_empty, w_closes;
    logic [ENTRY_W-1:0] w_entry, w_head;
    logic [REC_W-1:0]   w_rec;

    wss_front #(.POS_BITS(POS_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_sample      (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_buffer_last (s_axis_tlast),
        .i_queue_full  (w_full),
        .o_push        (w_push),
        .o_entry       (w_entry)
    );

    wss_queue #(.WIDTH(ENTRY_W), .DEPTH(wss_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_entry),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_empty     (w_empty),
        .o_head      (w_head)
    );

    wss_back #(.POS_BITS(POS_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_rec    (w_rec),
        .o_closes (w_closes),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'(w_rec);
    assign m_axis_tuser = w_closes;

endmodule

// ----- design/wss_checker.sv -----
// Port-level checks for the waveset segmenter, bound to the top level.
module wss_checker #(
    parameter int POS_BITS    = wss_pkg::POS_BITS_DEF,
    parameter int SAMPLE_BITS = wss_pkg::SAMPLE_BITS_DEF,
    localparam int REC_W      = 4 * POS_BITS + SAMPLE_BITS,
    localparam int OUT_W      = wss_pkg::byte_round(REC_W)
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [0:0]       m_axis_tuser,
    input logic             m_axis_tlast
);
    logic [POS_BITS-1:0] w_start, w_half;

    assign w_start = m_axis_tdata[POS_BITS-1:0];
    assign w_half  = m_axis_tdata[2*POS_BITS-1:POS_BITS];

    // Hold a stalled transaction.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Final record of a buffer is always the last one of its sample.
    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("buffer-closing record not marked last");

    a_half_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_half >= w_start)
        else $error("half position before start position");

endmodule

bind waveset_segmenter wss_checker #(
    .POS_BITS    (POS_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_wss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- dv/tb_waveset_segmenter.sv -----
// Testbench for waveset_segmenter: sample streams in, checked waveset records out.
module tb_waveset_segmenter;

    localparam int PB           = wss_pkg::POS_BITS_DEF;
    localparam int SB           = wss_pkg::SAMPLE_BITS_DEF;
    localparam int IN_W         = wss_pkg::byte_round(SB);
    localparam int OUT_W        = wss_pkg::byte_round(4 * PB + SB);
    localparam int MAX_WAIT     = 18;
    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 1850;

    typedef struct packed {
        logic [PB-1:0] start_pos;
        logic [PB-1:0] half_pos;
        logic [PB-1:0] end_pos;
        logic [SB-1:0] peak_level;
        logic [PB-1:0] waveset_index;
        logic          closes_buffer;
        logic          run_last;
    } t_waveset_rec;

    logic             i_clk;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;  // sample
    logic             s_axis_tlast  = 1'b0;  // buffer_last
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // start_pos, half_pos, end_pos, peak_level, waveset_index, zero fill
    logic [OUT_W-1:0] m_axis_tdata;
    logic [0:0]       m_axis_tuser;  // closes_buffer
    logic             m_axis_tlast;  // run_last

    waveset_segmenter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Segmenter state as the block should hold it
    logic          prev_neg;
    logic          second_half;
    logic [PB-1:0] start_r;
    logic [PB-1:0] half_r;
    logic [SB-1:0] peak_r;
    logic [PB-1:0] wave_pos;
    logic [PB-1:0] count_r;

    t_waveset_rec pending_wavesets[$];
    t_waveset_rec seen_rec;
    t_waveset_rec want_rec;
    int           fail_count    = 0;
    int           quiet_cycles  = 0;
    bit           src_gaps_on   = 1'b1;
    bit           snk_stalls_on = 1'b1;

    function automatic void clear_segmenter();
        prev_neg    = 1'b0;
        second_half = 1'b0;
        start_r     = '0;
        half_r      = '0;
        peak_r      = '0;
        wave_pos    = '0;
        count_r     = '0;
    endfunction

    initial clear_segmenter();

    // Append one record to the tail of the expected list
    function automatic void add_expected(input t_waveset_rec rec);
        pending_wavesets = {pending_wavesets, rec};
    endfunction

    function automatic void predict_wavesets(input logic [SB-1:0] smp, input logic lst);
        logic          neg;
        logic [SB-1:0] mag;
        logic [PB-1:0] p;
        neg = smp[SB-1];
        mag = neg ? (~smp + 1'b1) : smp;
        p   = wave_pos;
        // position zero only seeds the sign; a change is looked for from then on
        if (p != '0 && neg != prev_neg) begin
            if (!second_half) begin
                half_r      = p;
                second_half = 1'b1;
            end else begin
                add_expected('{start_r, half_r, p - 1'b1, peak_r, count_r, 1'b0, !lst});
                start_r     = p;
                half_r      = p;
                peak_r      = '0;
                second_half = 1'b0;
                if (count_r != '1) count_r = count_r + 1'b1;
            end
        end
        prev_neg = neg;
        if (mag > peak_r) peak_r = mag;
        if (lst) begin
            add_expected('{start_r, half_r, p, peak_r, count_r, 1'b1, 1'b1});
            clear_segmenter();
        end else if (wave_pos != '1) begin
            wave_pos = wave_pos + 1'b1;
        end
    endfunction

    task automatic note_failure(input string what, input t_waveset_rec want,
                                input t_waveset_rec got);
        fail_count++;
        if (fail_count <= 10)
            $display("%s: expected start=%0d half=%0d end=%0d peak=%0d index=%0d closes=%0b last=%0b",
                     what, want.start_pos, want.half_pos, want.end_pos, want.peak_level,
                     want.waveset_index, want.closes_buffer, want.run_last);
        if (fail_count <= 10)
            $display("    got start=%0d half=%0d end=%0d peak=%0d index=%0d closes=%0b last=%0b",
                     got.start_pos, got.half_pos, got.end_pos, got.peak_level,
                     got.waveset_index, got.closes_buffer, got.run_last);
    endtask

    // Compare each record transaction with the oldest expected record
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_rec = '{m_axis_tdata[PB-1:0], m_axis_tdata[2*PB-1:PB],
                         m_axis_tdata[3*PB-1:2*PB], m_axis_tdata[3*PB+SB-1:3*PB],
                         m_axis_tdata[4*PB+SB-1:3*PB+SB], m_axis_tuser[0], m_axis_tlast};
            if (pending_wavesets.size() == 0) begin
                note_failure("unexpected record", '0, seen_rec);
            end else begin
                want_rec = pending_wavesets.pop_front();
                if (want_rec !== seen_rec) note_failure("record mismatch", want_rec, seen_rec);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Record sink: random stall before each transaction
    initial begin
        int stall;
        forever begin
            stall = snk_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && m_axis_tvalid && m_axis_tready));
        end
    end

    // Offer one sample and hold it until its transaction completes
    task automatic send_sample(input logic [SB-1:0] smp, input logic lst);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= lst;
        predict_wavesets(smp, lst);
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_wavesets.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [SB-1:0] rand_sample(input logic neg);
        logic [SB-2:0] body;
        body = (SB-1)'($urandom);
        case ($urandom_range(0, 9))
            0:       return neg ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
            1:       return neg ? {SB{1'b1}} : {SB{1'b0}};
            default: return {neg, body};
        endcase
    endfunction

    // Extreme values, zero as non-negative, first sample, lone sample, no half,
    // half then last, and a close landing on the last sample
    task automatic test_buffer_edges();
        src_gaps_on   = 1'b1;
        snk_stalls_on = 1'b1;
        send_sample(24'h800000, 1'b0);
        send_sample(24'hFFFFFF, 1'b0);
        send_sample(24'h000000, 1'b0);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h800001, 1'b0);
        send_sample(24'h000001, 1'b0);
        send_sample(24'hFFFFFF, 1'b1);
        send_sample(24'h123456, 1'b1);
        send_sample(24'h000010, 1'b0);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h000000, 1'b1);
        send_sample(24'hFFFFF0, 1'b0);
        send_sample(24'h000000, 1'b0);
        send_sample(24'h555555, 1'b1);
    endtask

    // Buffers built from sign runs so wavesets form; some buffers are pure noise
    task automatic test_random_buffers();
        int   items_sent;
        int   buf_count;
        int   len;
        int   run;
        bit   noise;
        logic neg;
        items_sent = 0;
        buf_count  = 0;
        while (items_sent < RANDOM_ITEMS) begin
            src_gaps_on   = 1'($urandom_range(0, 1));
            snk_stalls_on = 1'($urandom_range(0, 1));
            len   = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 200)
                                                 : $urandom_range(1, 40);
            noise = ($urandom_range(0, 7) == 0);
            neg   = 1'($urandom_range(0, 1));
            run   = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                if (run == 0) begin
                    neg = ~neg;
                    run = $urandom_range(1, 8);
                end
                run--;
                send_sample(noise ? SB'($urandom) : rand_sample(neg), k == len - 1);
            end
            items_sent += len;
            buf_count++;
            if (buf_count % 16 == 8) hold_until_drained();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_buffer_edges();
        hold_until_drained();
        test_random_buffers();
        hold_until_drained();
        repeat (8) @(posedge i_clk);
        fail_count += pending_wavesets.size();
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
